// ===== rtl/core/afc_pkg.sv =====
// ============================================================================
// afc_pkg: shared types and constants for the box/frustum culling pipeline
// Holds the item carried between plane segments, the plane entry layout,
// result and command codes, and the corner-pair helpers.
// ============================================================================
package afc_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int FRAC_W         = 16;
    localparam int IDX_W          = 3;
    localparam int CNT_W          = 3;
    localparam int DEF_MAX_PLANES = 6;

    localparam logic [CNT_W-1:0] PLANE_COUNT_RESET = 3'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam logic [1:0] RES_OUTSIDE = 2'd0;
    localparam logic [1:0] RES_INSIDE  = 2'd1;
    localparam logic [1:0] RES_CROSS   = 2'd2;

    localparam logic [1:0] CODE_SAME = 2'd0;
    localparam logic [1:0] CODE_XY   = 2'd1;
    localparam logic [1:0] CODE_YZ   = 2'd2;
    localparam logic [1:0] CODE_XZ   = 2'd3;

    // Arithmetic widths: products, three-term sums, clip numerators.
    localparam int PROD_W    = 2 * COORD_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_W     = PROD_W + 3;
    localparam int MAG_W     = NUM_W - 1;
    localparam int Q_W       = COORD_WIDTH + 1;
    localparam int DIV_STEP  = 3;
    localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;

    // For a box test, data holds min x/y/z then max x/y/z.
    // For a plane load, data holds normal x/y/z then the offset.
    typedef struct packed {
        logic                             valid;
        logic                             is_test;
        logic                             done;
        logic [1:0]                       result;
        logic [IDX_W-1:0]                 idx;
        logic [5:0][COORD_WIDTH-1:0]      data;
    } item_t;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] n;
        logic [COORD_WIDTH-1:0]      d;
        logic [1:0]                  code;
    } plane_t;

    function automatic logic [1:0] corner_code_of(input logic [COORD_WIDTH-1:0] nx,
                                                  input logic [COORD_WIDTH-1:0] ny,
                                                  input logic [COORD_WIDTH-1:0] nz);
        logic sx, sy, sz;
        logic [1:0] code;
        sx = !nx[COORD_WIDTH-1] && (|nx);
        sy = !ny[COORD_WIDTH-1] && (|ny);
        sz = !nz[COORD_WIDTH-1] && (|nz);
        if (sx == sy && sy == sz) begin
            code = CODE_SAME;
        end else if (sx == sy) begin
            code = CODE_XY;
        end else if (sy == sz) begin
            code = CODE_YZ;
        end else begin
            code = CODE_XZ;
        end
        return code;
    endfunction

    // Bit a set: the first corner of the pair takes the max bound on axis a.
    function automatic logic [2:0] first_max(input logic [1:0] code);
        logic [2:0] m;
        case (code)
            CODE_SAME: m = 3'b000;
            CODE_XY:   m = 3'b100;
            CODE_YZ:   m = 3'b110;
            CODE_XZ:   m = 3'b010;
            default:   m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/afc_plane.sv =====
// ============================================================================
// afc_plane: one plane segment of the culling pipeline
// Holds one plane entry, tests a passing box against it, and clips the box
// through three pipelined restoring dividers when the box crosses the plane.
// ============================================================================
module afc_plane #(
    parameter int PLANE_ID = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic [afc_pkg::CNT_W:0]   count,
    input  afc_pkg::item_t            in_item,
    output afc_pkg::item_t            out_item
);
    import afc_pkg::*;

    localparam int CW = COORD_WIDTH;

    typedef struct packed {
        item_t                  item;
        plane_t                 pl;
        logic                   act;
        logic [2:0][PROD_W-1:0] p1;
        logic [2:0][PROD_W-1:0] p2;
    } st1_t;

    typedef struct packed {
        item_t                  item;
        plane_t                 pl;
        logic                   act;
        logic [2:0][PROD_W-1:0] p1;
        logic [2:0][PROD_W-1:0] p2;
        logic [SUM_W-1:0]       r1;
        logic [SUM_W-1:0]       r2;
        logic [SUM_W-1:0]       dd;
    } st2_t;

    typedef struct packed {
        item_t                  item;
        plane_t                 pl;
        logic                   clip;
        logic [2:0]             omax;
        logic [2:0][PROD_W-1:0] pin;
        logic [SUM_W-1:0]       rin;
        logic [SUM_W-1:0]       dd;
    } st3_t;

    typedef struct packed {
        item_t                 item;
        plane_t                pl;
        logic                  clip;
        logic [2:0]            omax;
        logic [2:0][NUM_W-1:0] num;
    } st4_t;

    typedef struct packed {
        logic [CW-1:0]  rem;
        logic [Q_W-1:0] low;
        logic [Q_W-1:0] q;
        logic [CW-1:0]  den;
        logic           neg;
        logic           sat;
        logic           skip;
    } dlane_t;

    typedef struct packed {
        item_t           item;
        logic            clip;
        logic [2:0]      omax;
        dlane_t [2:0]    lane;
    } dst_t;

    plane_t plane_reg;
    st1_t   st1_reg, st1_next;
    st2_t   st2_reg, st2_next;
    st3_t   st3_reg, st3_next;
    st4_t   st4_reg, st4_next;
    dst_t   dst_reg  [DIV_STAGES+1];
    dst_t   dst_next [DIV_STAGES+1];
    item_t  out_reg, out_next;

    logic load_hit;

    assign load_hit = in_item.valid && !in_item.is_test &&
                      (in_item.idx == IDX_W'(PLANE_ID));

    // The table entry is written as the load passes; every test copies the
    // entry when it enters, so later loads never disturb tests in flight.
    always_ff @(posedge aclk) begin
        if (adv && load_hit) begin
            plane_reg.n[0] <= in_item.data[0];
            plane_reg.n[1] <= in_item.data[1];
            plane_reg.n[2] <= in_item.data[2];
            plane_reg.d    <= in_item.data[3];
            plane_reg.code <= corner_code_of(in_item.data[0], in_item.data[1],
                                             in_item.data[2]);
        end
    end

    // Stage 1: corner products.
    always_comb begin
        logic [2:0] m1;
        logic [CW-1:0] c1, c2;
        st1_next      = '0;
        st1_next.item = in_item;
        st1_next.pl   = plane_reg;
        st1_next.act  = in_item.valid && in_item.is_test && !in_item.done &&
                        ((CNT_W+1)'(PLANE_ID) < count);
        m1 = first_max(plane_reg.code);
        for (int a = 0; a < 3; a++) begin
            c1 = m1[a] ? in_item.data[3+a] : in_item.data[a];
            c2 = m1[a] ? in_item.data[a]   : in_item.data[3+a];
            st1_next.p1[a] = PROD_W'($signed(c1) * $signed(plane_reg.n[a]));
            st1_next.p2[a] = PROD_W'($signed(c2) * $signed(plane_reg.n[a]));
        end
    end

    // Stage 2: dot products and the scaled offset.
    always_comb begin
        st2_next      = '0;
        st2_next.item = st1_reg.item;
        st2_next.pl   = st1_reg.pl;
        st2_next.act  = st1_reg.act;
        st2_next.p1   = st1_reg.p1;
        st2_next.p2   = st1_reg.p2;
        st2_next.r1   = SUM_W'($signed(st1_reg.p1[0])) + SUM_W'($signed(st1_reg.p1[1]))
                      + SUM_W'($signed(st1_reg.p1[2]));
        st2_next.r2   = SUM_W'($signed(st1_reg.p2[0])) + SUM_W'($signed(st1_reg.p2[1]))
                      + SUM_W'($signed(st1_reg.p2[2]));
        st2_next.dd   = SUM_W'($signed({st1_reg.pl.d, {FRAC_W{1'b0}}}));
    end

    // Stage 3: classify the box against the plane.
    always_comb begin
        logic out1, out2;
        logic [2:0] m1;
        out1 = $signed(st2_reg.dd) < $signed(st2_reg.r1);
        out2 = $signed(st2_reg.dd) < $signed(st2_reg.r2);
        m1   = first_max(st2_reg.pl.code);
        st3_next      = '0;
        st3_next.item = st2_reg.item;
        st3_next.pl   = st2_reg.pl;
        st3_next.dd   = st2_reg.dd;
        st3_next.pin  = out1 ? st2_reg.p2 : st2_reg.p1;
        st3_next.rin  = out1 ? st2_reg.r2 : st2_reg.r1;
        st3_next.omax = out1 ? m1 : ~m1;
        st3_next.clip = 1'b0;
        if (st2_reg.act) begin
            if (out1 && out2) begin
                st3_next.item.result = RES_OUTSIDE;
                st3_next.item.done   = 1'b1;
            end else if (out1 || out2) begin
                st3_next.item.result = RES_CROSS;
                st3_next.clip        = 1'b1;
            end
        end
    end

    // Stage 4: clip numerators, offset minus the other two axes' terms.
    always_comb begin
        st4_next      = '0;
        st4_next.item = st3_reg.item;
        st4_next.pl   = st3_reg.pl;
        st4_next.clip = st3_reg.clip;
        st4_next.omax = st3_reg.omax;
        for (int a = 0; a < 3; a++) begin
            st4_next.num[a] = NUM_W'($signed(st3_reg.dd)) - NUM_W'($signed(st3_reg.rin))
                            + NUM_W'($signed(st3_reg.pin[a]));
        end
    end

    // Stage 5: magnitudes, quotient sign and the overflow pre-check.
    always_comb begin
        logic [NUM_W-1:0] nabs;
        logic [MAG_W-1:0] mag;
        logic [CW-1:0]    nval, dabs;
        logic [Q_W-1:0]   hi;
        dst_next[0]      = '0;
        dst_next[0].item = st4_reg.item;
        dst_next[0].clip = st4_reg.clip;
        dst_next[0].omax = st4_reg.omax;
        for (int a = 0; a < 3; a++) begin
            nabs = st4_reg.num[a][NUM_W-1] ? (NUM_W'(0) - st4_reg.num[a]) : st4_reg.num[a];
            mag  = nabs[MAG_W-1:0];
            nval = st4_reg.pl.n[a];
            dabs = nval[CW-1] ? (CW'(0) - nval) : nval;
            hi   = mag[MAG_W-1:Q_W];
            dst_next[0].lane[a].sat  = hi >= {1'b0, dabs};
            dst_next[0].lane[a].rem  = hi[CW-1:0];
            dst_next[0].lane[a].low  = mag[Q_W-1:0];
            dst_next[0].lane[a].q    = '0;
            dst_next[0].lane[a].den  = dabs;
            dst_next[0].lane[a].neg  = st4_reg.num[a][NUM_W-1] ^ nval[CW-1];
            dst_next[0].lane[a].skip = (nval == '0);
        end
    end

    // Restoring division, DIV_STEP quotient bits per stage.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        always_comb begin
            logic [Q_W-1:0] sh;
            dst_next[s+1] = dst_reg[s];
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < DIV_STEP; j++) begin
                    if (s * DIV_STEP + j < Q_W) begin
                        sh = {dst_next[s+1].lane[a].rem, dst_next[s+1].lane[a].low[Q_W-1]};
                        dst_next[s+1].lane[a].low = dst_next[s+1].lane[a].low << 1;
                        if (sh >= {1'b0, dst_next[s+1].lane[a].den}) begin
                            sh = sh - {1'b0, dst_next[s+1].lane[a].den};
                            dst_next[s+1].lane[a].q = {dst_next[s+1].lane[a].q[Q_W-2:0], 1'b1};
                        end else begin
                            dst_next[s+1].lane[a].q = {dst_next[s+1].lane[a].q[Q_W-2:0], 1'b0};
                        end
                        dst_next[s+1].lane[a].rem = sh[CW-1:0];
                    end
                end
            end
        end
    end

    // Final stage: saturate, sign, and tighten the bound on the beyond side.
    always_comb begin
        dst_t            f;
        logic [Q_W-1:0]  lim, qs, tq;
        logic [CW-1:0]   t, pout;
        f        = dst_reg[DIV_STAGES];
        out_next = f.item;
        for (int a = 0; a < 3; a++) begin
            lim  = {1'b0, f.lane[a].neg, {(CW-1){!f.lane[a].neg}}};
            qs   = (f.lane[a].sat || f.lane[a].q > lim) ? lim : f.lane[a].q;
            tq   = f.lane[a].neg ? (Q_W'(0) - qs) : qs;
            t    = tq[CW-1:0];
            pout = f.omax[a] ? f.item.data[3+a] : f.item.data[a];
            if (f.clip && !f.lane[a].skip) begin
                if (f.omax[a]) begin
                    if ($signed(t) < $signed(pout)) begin
                        out_next.data[3+a] = t;
                    end
                end else begin
                    if ($signed(t) > $signed(pout)) begin
                        out_next.data[a] = t;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.item.valid <= 1'b0;
            st2_reg.item.valid <= 1'b0;
            st3_reg.item.valid <= 1'b0;
            st4_reg.item.valid <= 1'b0;
            out_reg.valid      <= 1'b0;
        end else if (adv) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            out_reg <= out_next;
        end
    end

    for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_dreg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dst_reg[s].item.valid <= 1'b0;
            end else if (adv) begin
                dst_reg[s] <= dst_next[s];
            end
        end
    end

    assign out_item = out_reg;

endmodule

// ===== rtl/core/aabb_frustum_cull.sv =====
// ============================================================================
// aabb_frustum_cull: streaming box-against-frustum culling pipeline
// Loads planes into a table and classifies boxes as outside, inside or
// intersecting, clipping each box to every plane it crosses.
// ============================================================================
// Usage:
// The s_ channel takes one request per cycle while s_ready is high. A request
// with s_cmd low loads plane s_plane_index; one with s_cmd high tests the box.
// Each test yields one m_cull_result on the m_ channel; loads yield nothing.
// Results leave in request order. The cfg channel writes plane_count (always
// ready) and must be used only while the pipeline is empty.
// Throughput is one request per cycle while s_ready is high. Each plane
// segment is a multiply stage, an add stage, a compare stage, a numerator
// stage, an operand stage, eleven stages of a three-bit-per-stage divider
// and a clip stage; one output register follows the last segment.
// Reset clears all valid bits and sets plane_count to six; the plane table
// holds no defined value until loaded. When the receiver stalls, the result
// waits in the output register and the pipeline keeps advancing until a
// second test reaches the end, after which s_ready drops.
// ============================================================================
module aabb_frustum_cull #(
    parameter int MAX_PLANES = afc_pkg::DEF_MAX_PLANES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [afc_pkg::IDX_W-1:0]          s_plane_index,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_normal_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_normal_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_normal_z,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_plane_offset,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_min_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_min_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_min_z,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_max_x,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_max_y,
    input  logic signed [afc_pkg::COORD_WIDTH-1:0] s_box_max_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_cull_result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [afc_pkg::CNT_W-1:0]          cfg_data
);
    import afc_pkg::*;

    logic [CNT_W-1:0] plane_count_reg;
    logic [CNT_W:0]   count;
    logic             adv;
    logic             last_test;
    logic             m_valid_reg;
    logic [1:0]       m_result_reg;
    item_t            chain [MAX_PLANES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg <= PLANE_COUNT_RESET;
        end else if (cfg_valid) begin
            plane_count_reg <= cfg_data;
        end
    end

    assign count = ({1'b0, plane_count_reg} > (CNT_W+1)'(MAX_PLANES)) ?
                   (CNT_W+1)'(MAX_PLANES) : {1'b0, plane_count_reg};

    always_comb begin
        chain[0]         = '0;
        chain[0].valid   = s_valid && s_ready;
        chain[0].is_test = (s_cmd == CMD_TEST);
        chain[0].done    = 1'b0;
        chain[0].result  = RES_INSIDE;
        chain[0].idx     = s_plane_index;
        if (s_cmd == CMD_TEST) begin
            chain[0].data = {s_box_max_z, s_box_max_y, s_box_max_x,
                             s_box_min_z, s_box_min_y, s_box_min_x};
        end else begin
            chain[0].data = {{2*COORD_WIDTH{1'b0}}, s_plane_offset,
                             s_normal_z, s_normal_y, s_normal_x};
        end
    end

    for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
        afc_plane #(
            .PLANE_ID (p)
        ) u_plane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .count    (count),
            .in_item  (chain[p]),
            .out_item (chain[p+1])
        );
    end

    // The pipeline only holds when a finished test has nowhere to go.
    assign last_test = chain[MAX_PLANES].valid && chain[MAX_PLANES].is_test;
    assign adv       = !last_test || !m_valid_reg || m_ready;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (adv && last_test) begin
                m_valid_reg  <= 1'b1;
                m_result_reg <= chain[MAX_PLANES].result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cull_result = m_result_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the output register could drain");

    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !last_test) |=> !m_valid)
        else $error("result repeated after it was taken");

    a_result_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cull_result == RES_OUTSIDE || m_cull_result == RES_INSIDE ||
                     m_cull_result == RES_CROSS))
        else $error("invalid cull result code");
`endif

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb: testbench for the aabb_frustum_cull culling pipeline
// Loads plane tables, streams boxes through the block under several plane
// counts and handshake idling patterns, and checks every cull result against
// an exact fixed-point predictor of the plane tests and the box clipping.
// ============================================================================
module tb;
    import afc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic        cmd;
        logic [2:0]  idx;
        logic [31:0] nrm [3];
        logic [31:0] ofs;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } request_t;

    localparam int NPLANES = DEF_MAX_PLANES;
    localparam int DRAIN_CYCLES = 130;
    localparam int STALL_LIMIT = 3000;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_cmd;
    logic [IDX_W-1:0] s_plane_index;
    logic signed [31:0] s_normal_x, s_normal_y, s_normal_z, s_plane_offset;
    logic signed [31:0] s_box_min_x, s_box_min_y, s_box_min_z;
    logic signed [31:0] s_box_max_x, s_box_max_y, s_box_max_z;
    logic m_valid, m_ready;
    logic [1:0] m_cull_result;
    logic cfg_valid, cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    aabb_frustum_cull uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_plane_index(s_plane_index),
        .s_normal_x(s_normal_x), .s_normal_y(s_normal_y), .s_normal_z(s_normal_z),
        .s_plane_offset(s_plane_offset),
        .s_box_min_x(s_box_min_x), .s_box_min_y(s_box_min_y), .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x), .s_box_max_y(s_box_max_y), .s_box_max_z(s_box_max_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_cull_result(m_cull_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    request_t    pending_requests [$];
    logic [1:0]  expected_results [$];
    int          idle_mode;
    int          fail_count;
    logic        s_taken;

    // Predictor copy of the plane table and the count register.
    longint      plane_nrm [NPLANES][3];
    longint      plane_ofs [NPLANES];
    logic [1:0]  plane_code [NPLANES];
    logic [2:0]  plane_count;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic wide_t wmul(input longint a, input longint b);
        wide_t x, y;
        x = a;
        y = b;
        return x * y;
    endfunction

    function automatic logic [1:0] corner_pair(input longint nx, input longint ny,
                                               input longint nz);
        bit sx, sy, sz;
        sx = nx > 0;
        sy = ny > 0;
        sz = nz > 0;
        if (sx == sy && sy == sz) return CODE_SAME;
        if (sx == sy) return CODE_XY;
        if (sy == sz) return CODE_YZ;
        return CODE_XZ;
    endfunction

    // Bit a set: the first corner of the pair takes the max bound on axis a.
    function automatic logic [2:0] max_axes(input logic [1:0] code);
        case (code)
            CODE_XY: return 3'b100;
            CODE_YZ: return 3'b110;
            CODE_XZ: return 3'b010;
            default: return 3'b000;
        endcase
    endfunction

    function automatic logic [1:0] classify_box(input request_t r);
        longint lo [3], hi [3], c1 [3], c2 [3], pin [3], pout [3], n [3], t;
        wide_t dd, r1, r2, num, q;
        logic [2:0] m1, m2, om;
        logic [1:0] res;
        int cnt;
        bit o1, o2;
        res = RES_INSIDE;
        for (int a = 0; a < 3; a++) begin
            lo[a] = longint'($signed(r.lo[a]));
            hi[a] = longint'($signed(r.hi[a]));
        end
        cnt = plane_count > NPLANES ? NPLANES : plane_count;
        for (int p = 0; p < cnt && res != RES_OUTSIDE; p++) begin
            m1 = max_axes(plane_code[p]);
            m2 = ~m1;
            dd = wmul(plane_ofs[p], 65536);
            r1 = 0;
            r2 = 0;
            for (int a = 0; a < 3; a++) begin
                n[a] = plane_nrm[p][a];
                c1[a] = m1[a] ? hi[a] : lo[a];
                c2[a] = m2[a] ? hi[a] : lo[a];
                r1 += wmul(c1[a], n[a]);
                r2 += wmul(c2[a], n[a]);
            end
            o1 = dd < r1;
            o2 = dd < r2;
            if (o1 && o2) begin
                res = RES_OUTSIDE;
            end else if (o1 || o2) begin
                res = RES_CROSS;
                pin = o1 ? c2 : c1;
                pout = o1 ? c1 : c2;
                om = o1 ? m1 : m2;
                for (int a = 0; a < 3; a++) begin
                    if (n[a] != 0) begin
                        num = dd;
                        for (int b = 0; b < 3; b++)
                            if (b != a) num -= wmul(pin[b], n[b]);
                        // Signed division truncates toward zero, then saturate.
                        q = num / wide_t'(n[a]);
                        if (q > 64'sd2147483647) t = 64'sd2147483647;
                        else if (q < -64'sd2147483648) t = -64'sd2147483648;
                        else t = longint'(q);
                        if (om[a]) begin
                            if (t < pout[a]) hi[a] = t;
                        end else begin
                            if (t > pout[a]) lo[a] = t;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // Mostly moderate magnitudes so that boxes land near planes, some full range.
    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:    return 32'd0;
            3:    return {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
            default: return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh1F_FFFF);
        endcase
    endfunction

    function automatic request_t rand_plane(input logic [2:0] idx);
        request_t r;
        r.cmd = CMD_LOAD;
        r.idx = idx;
        for (int a = 0; a < 3; a++) begin
            r.nrm[a] = ($urandom_range(0, 4) == 0) ? 32'd0 : rand_val();
            r.lo[a] = $urandom;
            r.hi[a] = $urandom;
        end
        r.ofs = rand_val();
        return r;
    endfunction

    function automatic request_t rand_box();
        request_t r;
        r.cmd = CMD_TEST;
        r.idx = 3'($urandom);
        r.ofs = $urandom;
        for (int a = 0; a < 3; a++) begin
            r.nrm[a] = $urandom;
            r.lo[a] = rand_val();
            // Usually a proper box; now and then an inverted or arbitrary one.
            r.hi[a] = ($urandom_range(0, 7) == 0) ? rand_val()
                      : r.lo[a] + $urandom_range(0, 32'h3F_FFFF);
        end
        return r;
    endfunction

    function automatic request_t fixed_box(input logic [31:0] l, input logic [31:0] h);
        request_t r;
        r = rand_box();
        for (int a = 0; a < 3; a++) begin
            r.lo[a] = l;
            r.hi[a] = h;
        end
        return r;
    endfunction

    // Driver: presents queued requests at the falling edge.
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (!s_valid || s_taken) begin
                if (pending_requests.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(0, 99) < 76) ||
                      (idle_mode == 3 && $urandom_range(0, 99) < 33))) begin
                    r = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= r.cmd;
                    s_plane_index <= r.idx;
                    s_normal_x <= r.nrm[0];
                    s_normal_y <= r.nrm[1];
                    s_normal_z <= r.nrm[2];
                    s_plane_offset <= r.ofs;
                    s_box_min_x <= r.lo[0];
                    s_box_min_y <= r.lo[1];
                    s_box_min_z <= r.lo[2];
                    s_box_max_x <= r.hi[0];
                    s_box_max_y <= r.hi[1];
                    s_box_max_z <= r.hi[2];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 76) ||
                         (idle_mode == 3 && $urandom_range(0, 99) < 33));
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge aclk) begin
        request_t r;
        logic [1:0] want;
        if (!aresetn) begin
            s_taken <= 1'b0;
            plane_count = PLANE_COUNT_RESET;
        end else begin
            s_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                plane_count = cfg_data;
            if (s_valid && s_ready) begin
                r.cmd = s_cmd;
                r.idx = s_plane_index;
                r.nrm[0] = s_normal_x;
                r.nrm[1] = s_normal_y;
                r.nrm[2] = s_normal_z;
                r.ofs = s_plane_offset;
                r.lo[0] = s_box_min_x;
                r.lo[1] = s_box_min_y;
                r.lo[2] = s_box_min_z;
                r.hi[0] = s_box_max_x;
                r.hi[1] = s_box_max_y;
                r.hi[2] = s_box_max_z;
                if (r.cmd == CMD_TEST) begin
                    expected_results.push_back(classify_box(r));
                end else if (r.idx < NPLANES) begin
                    for (int a = 0; a < 3; a++)
                        plane_nrm[r.idx][a] = longint'($signed(r.nrm[a]));
                    plane_ofs[r.idx] = longint'($signed(r.ofs));
                    plane_code[r.idx] = corner_pair(plane_nrm[r.idx][0],
                                                    plane_nrm[r.idx][1],
                                                    plane_nrm[r.idx][2]);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: cull_result actual %0d", m_cull_result);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_cull_result !== want) begin
                        $error("cull_result mismatch: expected %0d actual %0d",
                               want, m_cull_result);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles without any handshake while work is outstanding.
    always @(posedge aclk) begin
        static int quiet = 0;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            (pending_requests.size() == 0 && expected_results.size() == 0 && !s_valid &&
             !cfg_valid)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        wait (pending_requests.size() == 0);
        @(posedge aclk);
        while (s_valid && !s_ready) @(posedge aclk);
        wait (expected_results.size() == 0);
        // Plane loads yield no result, so let the pipeline empty out.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input logic [2:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        request_t r;
        logic [2:0] counts [8] = '{3'd6, 3'd3, 3'd7, 3'd1, 3'd0, 3'd6, 3'd2, 3'd5};
        fail_count = 0;
        idle_mode = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = CMD_LOAD;
        s_plane_index = '0;
        {s_normal_x, s_normal_y, s_normal_z, s_plane_offset} = '0;
        {s_box_min_x, s_box_min_y, s_box_min_z} = '0;
        {s_box_max_x, s_box_max_y, s_box_max_z} = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every slot loaded before any test, extreme planes included.
        r = rand_plane(0);
        r.nrm = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        r.ofs = 32'h0010_0000;
        pending_requests.push_back(r);
        r = rand_plane(1);
        r.nrm = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
        r.ofs = 32'h7FFF_FFFF;
        pending_requests.push_back(r);
        r = rand_plane(2);
        r.nrm = '{32'd0, 32'd0, 32'd0};
        r.ofs = 32'h0000_0000;
        pending_requests.push_back(r);
        r = rand_plane(3);
        r.nrm = '{32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000};
        r.ofs = 32'h8000_0000;
        pending_requests.push_back(r);
        r = rand_plane(4);
        r.nrm = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};
        r.ofs = 32'h0000_8000;
        pending_requests.push_back(r);
        r = rand_plane(5);
        r.nrm = '{32'hFFFF_FFFF, 32'h0002_0000, 32'hFFFF_8000};
        r.ofs = 32'hFFF0_0000;
        pending_requests.push_back(r);
        // Out-of-range slots must be ignored.
        pending_requests.push_back(rand_plane(6));
        pending_requests.push_back(rand_plane(7));
        pending_requests.push_back(fixed_box(32'h0, 32'h0));
        pending_requests.push_back(fixed_box(32'h8000_0000, 32'h7FFF_FFFF));
        pending_requests.push_back(fixed_box(32'h7FFF_FFFF, 32'h8000_0000));
        pending_requests.push_back(fixed_box(32'hFFFF_FFFF, 32'h0000_0001));
        pending_requests.push_back(fixed_box(32'h0008_0000, 32'h0018_0000));
        pending_requests.push_back(fixed_box(32'hFFF0_0000, 32'h0001_0000));
        // A zero-normal plane with a negative offset puts everything outside.
        r = rand_plane(2);
        r.nrm = '{32'd0, 32'd0, 32'd0};
        r.ofs = 32'hFFFF_FFFF;
        pending_requests.push_back(r);
        pending_requests.push_back(fixed_box(32'h0, 32'h0001_0000));
        for (int i = 0; i < 6; i++) pending_requests.push_back(rand_box());
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_count(counts[ph]);
            idle_mode = ph % 4;
            for (int i = 0; i < 80; i++)
                pending_requests.push_back($urandom_range(0, 3) == 0 ?
                                           rand_plane(3'($urandom_range(0, 7))) :
                                           rand_box());
            wait_drained();
        end

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
